>>> rtl/core/kvi_pkg.sv
// Shared types, codes and widths for the keyframe vertex interpolator.
`timescale 1ns / 1ps
package kvi_pkg;
	localparam int TIME_W     = 32;
	localparam int VAL_W      = 32;
	localparam int DUR_W      = 31;
	localparam int CNT_CFG_W  = 7;
	localparam int IDX_OUT_W  = 6;
	localparam int FRAC_W     = 16;
	localparam int TFRAC_W    = FRAC_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int DIV_NUM_W  = 49;
	localparam int DIV_DEN_W  = 33;
	localparam int DIV_STEPS  = 49;
	localparam int DIV_CNT_W  = 6;

	typedef logic [1:0] action_t;
	localparam action_t ACT_STAGE  = 2'd0;
	localparam action_t ACT_COMMIT = 2'd1;
	localparam action_t ACT_QUERY  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_EMPTY     = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_COMMITTED = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LOOP     = 2'd0;
	localparam cfg_idx_t CFG_DURATION = 2'd1;
	localparam cfg_idx_t CFG_COUNT    = 2'd2;

	localparam logic [DUR_W-1:0]     DUR_RESET = 31'd65536;
	localparam logic [CNT_CFG_W-1:0] CNT_RESET = 7'd64;

	typedef struct packed {
		logic    stage_we;
		logic    latch_item;
		logic    key_rd;
		logic    key_wr;
		logic    key_wr_new;
		logic    cp_rd;
		logic    norm_start;
		logic    nt_take;
		logic    first_ld;
		logic    prev_ld;
		logic    pair_ld;
		logic    single_first;
		logic    single_cur;
		logic    t_start;
		logic    t_zero;
		logic    t_take;
		logic    vx_rd;
		logic    mul_ld;
		logic    out_ld_data;
		logic    out_ld_resp;
		status_t resp_code;
	} kvi_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic cur_gt_t;
		logic nt_ge_prev;
		logic nt_le_cur;
		logic nt_lt_first;
		logic span_zero;
		logic out_free;
	} kvi_sts_t;
endpackage

>>> rtl/core/kvi_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module kvi_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [kvi_pkg::DIV_NUM_W-1:0]  dividend,
	input  logic [kvi_pkg::DIV_DEN_W-1:0]  divisor,
	output logic                           busy,
	output logic [kvi_pkg::DIV_NUM_W-1:0]  quotient,
	output logic [kvi_pkg::DIV_DEN_W-1:0]  remainder
);
	import kvi_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 ge;

	assign trial     = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

>>> rtl/core/kvi_dp.sv
// Datapath: config registers, key table, vertex and staging memories, math, output register.
`timescale 1ns / 1ps
module kvi_dp #(
	parameter int MAX_KEYS       = 16,
	parameter int MAX_COMPONENTS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  kvi_pkg::kvi_cmd_t                      cmd,
	output kvi_pkg::kvi_sts_t                      sts,
	input  logic [$clog2(MAX_KEYS)-1:0]            key_raddr,
	input  logic [$clog2(MAX_KEYS)-1:0]            key_waddr,
	input  logic [$clog2(MAX_KEYS)-1:0]            key_slot,
	input  logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] comp_idx,
	output logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] last_idx,
	input  logic                                   cfg_we,
	input  logic [kvi_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [kvi_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [kvi_pkg::TIME_W-1:0]      time_value,
	input  logic [kvi_pkg::IDX_OUT_W-1:0]          component_index,
	input  logic signed [kvi_pkg::VAL_W-1:0]       component_value,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic signed [kvi_pkg::VAL_W-1:0]       component_out,
	output logic [kvi_pkg::IDX_OUT_W-1:0]          out_index,
	output logic                                   last,
	output logic [1:0]                             status
);
	import kvi_pkg::*;

	localparam int KW     = $clog2(MAX_KEYS);
	localparam int CW     = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int EW     = TIME_W + KW;
	localparam int VDEPTH = MAX_KEYS * (1 << CW);
	localparam int PW     = TFRAC_W + 1 + VAL_W + 1;

	// config
	logic                 loop_q;
	logic [DUR_W-1:0]     dur_q;
	logic [CNT_CFG_W-1:0] cc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
			dur_q  <= DUR_RESET;
			cc_q   <= CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOOP:     loop_q <= cfg_data[0];
				CFG_DURATION: dur_q  <= cfg_data[DUR_W-1:0];
				CFG_COUNT:    cc_q   <= cfg_data[CNT_CFG_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		if (cc_q == '0)
			last_idx = '0;
		else if (cc_q > CNT_CFG_W'(MAX_COMPONENTS))
			last_idx = CW'(MAX_COMPONENTS - 1);
		else
			last_idx = CW'(cc_q - 1'b1);
	end

	// memories
	logic [VAL_W-1:0] stg_mem [MAX_COMPONENTS];
	logic [VAL_W-1:0] vx_mem  [VDEPTH];
	logic [EW-1:0]    key_mem [MAX_KEYS];

	logic signed [TIME_W-1:0] t_q;
	logic [EW-1:0]            key_rd_q;
	logic [EW-1:0]            first_q, prev_q, a_q, b_q;
	logic [VAL_W-1:0]         stg_rd_q;
	logic                     cp_wr_s1;
	logic [CW-1:0]            cp_idx_s1;

	always_ff @(posedge clk) begin
		if (cmd.stage_we && ({1'b0, component_index} < (IDX_OUT_W + 1)'(MAX_COMPONENTS)))
			stg_mem[component_index[CW-1:0]] <= component_value;
		if (cmd.cp_rd)
			stg_rd_q <= stg_mem[comp_idx];
		cp_idx_s1 <= comp_idx;
		if (cp_wr_s1)
			vx_mem[{key_slot, cp_idx_s1}] <= stg_rd_q;
		if (cmd.key_rd)
			key_rd_q <= key_mem[key_raddr];
		if (cmd.key_wr)
			key_mem[key_waddr] <= cmd.key_wr_new ? {t_q, key_slot} : key_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cp_wr_s1 <= 1'b0;
		else
			cp_wr_s1 <= cmd.cp_rd;
	end

	// search bookkeeping
	logic signed [TIME_W-1:0] rd_time, prev_time, first_time, a_time, b_time, nt_s;
	logic [DUR_W-1:0]         nt_q;

	assign rd_time    = key_rd_q[EW-1 -: TIME_W];
	assign prev_time  = prev_q[EW-1 -: TIME_W];
	assign first_time = first_q[EW-1 -: TIME_W];
	assign a_time     = a_q[EW-1 -: TIME_W];
	assign b_time     = b_q[EW-1 -: TIME_W];
	assign nt_s       = {1'b0, nt_q};

	always_ff @(posedge clk) begin
		if (cmd.latch_item)
			t_q <= time_value;
		if (cmd.first_ld)
			first_q <= key_rd_q;
		if (cmd.prev_ld)
			prev_q <= key_rd_q;
		if (cmd.pair_ld) begin
			a_q <= prev_q;
			b_q <= key_rd_q;
		end else if (cmd.single_cur) begin
			a_q <= key_rd_q;
			b_q <= key_rd_q;
		end else if (cmd.single_first) begin
			a_q <= first_q;
			b_q <= first_q;
		end
	end

	// shared divider: time wrap, then the interpolation fraction
	logic                    div_busy;
	logic [DIV_NUM_W-1:0]    div_quo;
	logic [DIV_DEN_W-1:0]    div_rem;
	logic [DIV_NUM_W-1:0]    div_num;
	logic [DIV_DEN_W-1:0]    div_den;
	logic                    mod_go;
	logic [TIME_W-1:0]       abs_t;
	logic signed [TIME_W:0]  span, diff_t;
	logic [DUR_W-1:0]        nt_wrap, nt_clamp;
	logic                    mod_run_q;
	logic [TFRAC_W-1:0]      tfrac_q;

	assign mod_go = cmd.norm_start && loop_q && (dur_q != '0);
	assign abs_t  = t_q[TIME_W-1] ? TIME_W'(-t_q) : t_q;
	assign span   = {b_time[TIME_W-1], b_time} - {a_time[TIME_W-1], a_time};
	assign diff_t = {nt_s[TIME_W-1], nt_s} - {a_time[TIME_W-1], a_time};

	always_comb begin
		if (cmd.t_start) begin
			div_num = {diff_t, {FRAC_W{1'b0}}};
			div_den = span;
		end else begin
			div_num = {{(DIV_NUM_W - TIME_W){1'b0}}, abs_t};
			div_den = {{(DIV_DEN_W - DUR_W){1'b0}}, dur_q};
		end
	end

	kvi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_go || cmd.t_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// negative times wrap up from the top of the range
	assign nt_wrap = (t_q[TIME_W-1] && (div_rem != '0)) ? dur_q - div_rem[DUR_W-1:0]
		: div_rem[DUR_W-1:0];

	always_comb begin
		if (t_q[TIME_W-1])
			nt_clamp = '0;
		else if (t_q[DUR_W-1:0] > dur_q)
			nt_clamp = dur_q;
		else
			nt_clamp = t_q[DUR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_run_q <= 1'b0;
		else if (cmd.norm_start)
			mod_run_q <= mod_go;
	end

	always_ff @(posedge clk) begin
		if (cmd.norm_start) begin
			if (dur_q == '0)
				nt_q <= '0;
			else if (!loop_q)
				nt_q <= nt_clamp;
		end else if (cmd.nt_take && mod_run_q) begin
			nt_q <= nt_wrap;
		end
		if (cmd.t_zero)
			tfrac_q <= '0;
		else if (cmd.t_take)
			tfrac_q <= div_quo[TFRAC_W-1:0];
	end

	// per-component blend
	logic [VAL_W-1:0]       va_q, vb_q;
	logic signed [VAL_W:0]  diff_v;
	logic signed [PW-1:0]   prod_q;
	logic signed [VAL_W-1:0] base_q;
	logic signed [PW-1:0]   blend;

	assign diff_v = $signed({vb_q[VAL_W-1], vb_q}) - $signed({va_q[VAL_W-1], va_q});
	assign blend  = (prod_q >>> FRAC_W) + PW'(base_q);

	always_ff @(posedge clk) begin
		if (cmd.vx_rd) begin
			va_q <= vx_mem[{a_q[KW-1:0], comp_idx}];
			vb_q <= vx_mem[{b_q[KW-1:0], comp_idx}];
		end
		if (cmd.mul_ld) begin
			prod_q <= PW'($signed({1'b0, tfrac_q}) * diff_v);
			base_q <= va_q;
		end
	end

	// output register
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] comp_out_q;
	logic [IDX_OUT_W-1:0]    out_index_q;
	logic                    last_q;
	status_t                 status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld_data || cmd.out_ld_resp)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld_data) begin
			comp_out_q  <= blend[VAL_W-1:0];
			out_index_q <= IDX_OUT_W'(comp_idx);
			last_q      <= comp_idx == last_idx;
			status_q    <= ST_OK;
		end else if (cmd.out_ld_resp) begin
			comp_out_q  <= '0;
			out_index_q <= '0;
			last_q      <= 1'b1;
			status_q    <= cmd.resp_code;
		end
	end

	assign out_valid     = out_valid_q;
	assign component_out = comp_out_q;
	assign out_index     = out_index_q;
	assign last          = last_q;
	assign status        = status_q;

	assign sts.div_busy    = div_busy;
	assign sts.cur_gt_t    = rd_time > t_q;
	assign sts.nt_ge_prev  = nt_s >= prev_time;
	assign sts.nt_le_cur   = nt_s <= rd_time;
	assign sts.nt_lt_first = nt_s < first_time;
	assign sts.span_zero   = a_time == b_time;
	assign sts.out_free    = !out_valid_q || !out_stall;
endmodule

>>> rtl/core/kvi_ctrl.sv
// Controller: sequences staging, sorted insert, copy, search, divide and emit.
`timescale 1ns / 1ps
module kvi_ctrl #(
	parameter int MAX_KEYS       = 16,
	parameter int MAX_COMPONENTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	output kvi_pkg::kvi_cmd_t           cmd,
	input  kvi_pkg::kvi_sts_t           sts,
	output logic [$clog2(MAX_KEYS)-1:0] key_raddr,
	output logic [$clog2(MAX_KEYS)-1:0] key_waddr,
	output logic [$clog2(MAX_KEYS)-1:0] key_slot,
	output logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] comp_idx,
	input  logic [((MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1)-1:0] last_idx
);
	import kvi_pkg::*;

	localparam int KW = $clog2(MAX_KEYS);
	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_C_RD    = 4'd1;
	localparam logic [3:0] S_C_CMP   = 4'd2;
	localparam logic [3:0] S_C_INS   = 4'd3;
	localparam logic [3:0] S_CP_RUN  = 4'd4;
	localparam logic [3:0] S_CP_END  = 4'd5;
	localparam logic [3:0] S_RESP    = 4'd6;
	localparam logic [3:0] S_N_START = 4'd7;
	localparam logic [3:0] S_N_WAIT  = 4'd8;
	localparam logic [3:0] S_S_RD    = 4'd9;
	localparam logic [3:0] S_S_CMP   = 4'd10;
	localparam logic [3:0] S_T_START = 4'd11;
	localparam logic [3:0] S_T_WAIT  = 4'd12;
	localparam logic [3:0] S_E_RD    = 4'd13;
	localparam logic [3:0] S_E_MUL   = 4'd14;
	localparam logic [3:0] S_E_OUT   = 4'd15;

	logic [3:0]    state_q, state_d;
	logic [NW-1:0] count_q, count_d;
	logic [KW-1:0] kidx_q, kidx_d;
	logic [CW-1:0] cidx_q, cidx_d;
	status_t       resp_q, resp_d;
	logic          take;
	logic [KW-1:0] last_key;

	assign in_stall  = state_q != S_IDLE;
	assign take      = in_valid && !in_stall;
	assign last_key  = KW'(count_q - 1'b1);
	assign key_raddr = kidx_q;
	assign key_slot  = count_q[KW-1:0];
	assign comp_idx  = cidx_q;

	always_comb begin
		cmd       = '0;
		cmd.resp_code = resp_q;
		state_d   = state_q;
		count_d   = count_q;
		kidx_d    = kidx_q;
		cidx_d    = cidx_q;
		resp_d    = resp_q;
		key_waddr = KW'(kidx_q + 1'b1);
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (action)
						ACT_STAGE: cmd.stage_we = 1'b1;
						ACT_COMMIT: begin
							cmd.latch_item = 1'b1;
							if (count_q == NW'(MAX_KEYS)) begin
								resp_d  = ST_FULL;
								state_d = S_RESP;
							end else if (count_q == '0) begin
								state_d = S_C_INS;
							end else begin
								kidx_d  = last_key;
								state_d = S_C_RD;
							end
						end
						ACT_QUERY: begin
							cmd.latch_item = 1'b1;
							if (count_q == '0) begin
								resp_d  = ST_EMPTY;
								state_d = S_RESP;
							end else begin
								state_d = S_N_START;
							end
						end
						default: ;
					endcase
				end
			end
			S_C_RD: begin
				cmd.key_rd = 1'b1;
				state_d    = S_C_CMP;
			end
			S_C_CMP: begin
				cmd.key_wr = 1'b1;
				// later keys move up one place; ties stay in front of the new key
				if (sts.cur_gt_t) begin
					if (kidx_q == '0) begin
						state_d = S_C_INS;
					end else begin
						kidx_d  = kidx_q - 1'b1;
						state_d = S_C_RD;
					end
				end else begin
					cmd.key_wr_new = 1'b1;
					cidx_d         = '0;
					state_d        = S_CP_RUN;
				end
			end
			S_C_INS: begin
				key_waddr      = '0;
				cmd.key_wr     = 1'b1;
				cmd.key_wr_new = 1'b1;
				cidx_d         = '0;
				state_d        = S_CP_RUN;
			end
			S_CP_RUN: begin
				cmd.cp_rd = 1'b1;
				if (cidx_q == CW'(MAX_COMPONENTS - 1))
					state_d = S_CP_END;
				else
					cidx_d = cidx_q + 1'b1;
			end
			S_CP_END: begin
				count_d = count_q + 1'b1;
				resp_d  = ST_COMMITTED;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_ld_resp = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_N_START: begin
				cmd.norm_start = 1'b1;
				state_d        = S_N_WAIT;
			end
			S_N_WAIT: begin
				if (!sts.div_busy) begin
					cmd.nt_take = 1'b1;
					kidx_d      = '0;
					state_d     = S_S_RD;
				end
			end
			S_S_RD: begin
				cmd.key_rd = 1'b1;
				state_d    = S_S_CMP;
			end
			S_S_CMP: begin
				if (kidx_q == '0) begin
					cmd.first_ld = 1'b1;
					cmd.prev_ld  = 1'b1;
					if (count_q == NW'(1)) begin
						cmd.single_cur = 1'b1;
						state_d        = S_T_START;
					end else begin
						kidx_d  = KW'(1);
						state_d = S_S_RD;
					end
				end else if (sts.nt_ge_prev && sts.nt_le_cur) begin
					cmd.pair_ld = 1'b1;
					state_d     = S_T_START;
				end else begin
					cmd.prev_ld = 1'b1;
					if (kidx_q == last_key) begin
						// no bracketing pair: hold the first or the last key
						if (sts.nt_lt_first)
							cmd.single_first = 1'b1;
						else
							cmd.single_cur = 1'b1;
						state_d = S_T_START;
					end else begin
						kidx_d  = kidx_q + 1'b1;
						state_d = S_S_RD;
					end
				end
			end
			S_T_START: begin
				cidx_d = '0;
				if (sts.span_zero) begin
					cmd.t_zero = 1'b1;
					state_d    = S_E_RD;
				end else begin
					cmd.t_start = 1'b1;
					state_d     = S_T_WAIT;
				end
			end
			S_T_WAIT: begin
				if (!sts.div_busy) begin
					cmd.t_take = 1'b1;
					state_d    = S_E_RD;
				end
			end
			S_E_RD: begin
				cmd.vx_rd = 1'b1;
				state_d   = S_E_MUL;
			end
			S_E_MUL: begin
				cmd.mul_ld = 1'b1;
				state_d    = S_E_OUT;
			end
			S_E_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld_data = 1'b1;
					if (cidx_q == last_idx) begin
						state_d = S_IDLE;
					end else begin
						cidx_d  = cidx_q + 1'b1;
						state_d = S_E_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			kidx_q  <= '0;
			cidx_q  <= '0;
			resp_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			kidx_q  <= kidx_d;
			cidx_q  <= cidx_d;
			resp_q  <= resp_d;
		end
	end
endmodule

>>> rtl/core/keyframe_vertex_interpolator.sv
// Keyframe vertex interpolator: controller plus datapath.
// Stage writes one component into the staging memory. Commit moves later keys up one place,
//   inserts the new key, copies MAX_COMPONENTS components and replies; a full table only replies.
// Query: an empty table only replies; else wrap the time (divider, loop mode with nonzero duration),
//   search the keys, divide for a nonzero span and emit each component, one request at a time.
// Reset clears control, key count and config (loop 0, duration 65536, count 64), not memories.
`timescale 1ns / 1ps
module keyframe_vertex_interpolator #(
	parameter int MAX_KEYS       = 16,
	parameter int MAX_COMPONENTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic signed [kvi_pkg::TIME_W-1:0]   time_value,
	input  logic [kvi_pkg::IDX_OUT_W-1:0]       component_index,
	input  logic signed [kvi_pkg::VAL_W-1:0]    component_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [kvi_pkg::VAL_W-1:0]    component_out,
	output logic [kvi_pkg::IDX_OUT_W-1:0]       out_index,
	output logic                                last,
	output logic [1:0]                          status,
	input  logic                                cfg_we,
	input  logic [kvi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kvi_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import kvi_pkg::*;

	localparam int KW = $clog2(MAX_KEYS);
	localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

	kvi_cmd_t      cmd;
	kvi_sts_t      sts;
	logic [KW-1:0] key_raddr, key_waddr, key_slot;
	logic [CW-1:0] comp_idx, last_idx;

	kvi_ctrl #(
		.MAX_KEYS       (MAX_KEYS),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.cmd       (cmd),
		.sts       (sts),
		.key_raddr (key_raddr),
		.key_waddr (key_waddr),
		.key_slot  (key_slot),
		.comp_idx  (comp_idx),
		.last_idx  (last_idx)
	);

	kvi_dp #(
		.MAX_KEYS       (MAX_KEYS),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.key_raddr       (key_raddr),
		.key_waddr       (key_waddr),
		.key_slot        (key_slot),
		.comp_idx        (comp_idx),
		.last_idx        (last_idx),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.time_value      (time_value),
		.component_index (component_index),
		.component_value (component_value),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.component_out   (component_out),
		.out_index       (out_index),
		.last            (last),
		.status          (status)
	);
endmodule
